FILE: hdl/binary_to_decimal_ascii_core_macros.svh
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define B2DA_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("b2da check failed");

// next-cycle implication
`define B2DA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("b2da check failed");

`else

`define B2DA_ASSERT_IMPLIES(label, clk, rst, a, b)
`define B2DA_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // width of the converted value and of the input word field
  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;

  // decimal digits needed for VALUE_BITS bits: floor(n*log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;

  localparam int BCD_BITS   = 4;
  localparam int CHAR_BITS  = 6;
  localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
  localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);

  // operation applied to every digit cell alike
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_DIGIT
  } cell_op_t;

endpackage

FILE: hdl/b2da_if.sv
// ----------------------------------------------------------------------------
// b2da_in_if / b2da_out_if
// Valid/ready channels of the converter: binary words in, characters out.
// ----------------------------------------------------------------------------
interface b2da_in_if
  import b2da_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [IN_BITS-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if
  import b2da_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: hdl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Unsigned binary word to decimal ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// One word is taken while the core is idle. A chain of BCD digit cells runs
// double dabble, one input bit per cycle, then the chain shifts digits out
// of its top cell one per cycle: leading zeros are dropped, each remaining
// digit is sent as one output word when the output slot is free, the last
// one flagged. The output register lets the final character wait while the
// next word loads.
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core
  import b2da_pkg::*;
(
  input  logic clk,
  input  logic rst,
  b2da_in_if.sink    din,
  b2da_out_if.source dout
);

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    EMIT
  } state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   shreg;
  logic [BIT_CNT_BITS-1:0] bit_cnt;
  logic [REM_BITS-1:0]     remaining;
  logic                    started;
  logic                    out_valid;
  logic [CHAR_BITS-1:0]    out_char;
  logic                    out_last;

  cell_op_t                op;
  logic [BCD_BITS-1:0]     top_digit;
  logic                    skip;
  logic                    emit_go;

  // digit cells
  b2da_chain u_chain (
    .clk       (clk),
    .op        (op),
    .bit_in    (shreg[VALUE_BITS-1]),
    .top_digit (top_digit)
  );

  assign din.ready       = (state == IDLE);
  assign dout.valid      = out_valid;
  assign dout.digit_char = out_char;
  assign dout.last_digit = out_last;

  // leading zero drop (only before the first sent digit) and output slot check
  assign skip    = (state == EMIT) && !started && (top_digit == '0) &&
                   (remaining > REM_BITS'(1));
  assign emit_go = (state == EMIT) && !skip && (!out_valid || dout.ready);

  // chain operation
  always_comb begin
    op = OP_HOLD;
    case (state)
      IDLE:    if (din.valid) op = OP_CLEAR;
      CONVERT: op = OP_DABBLE;
      EMIT:    if (skip || emit_go) op = OP_DIGIT;
      default: op = OP_HOLD;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // output slot: filled by an emitted digit, freed when taken
      if (emit_go) out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (din.valid) begin
            shreg   <= VALUE_BITS'(din.value);
            bit_cnt <= BIT_CNT_BITS'(VALUE_BITS - 1);
            started <= 1'b0;
            state   <= CONVERT;
          end
        end
        CONVERT: begin
          shreg <= shreg << 1;
          if (bit_cnt == '0) begin
            remaining <= REM_BITS'(NUM_DIGITS);
            state     <= EMIT;
          end else begin
            bit_cnt <= bit_cnt - BIT_CNT_BITS'(1);
          end
        end
        EMIT: begin
          if (skip) begin
            remaining <= remaining - REM_BITS'(1);
          end else if (emit_go) begin
            out_char  <= ASCII_ZERO + CHAR_BITS'(top_digit);
            out_last  <= (remaining == REM_BITS'(1));
            started   <= 1'b1;
            remaining <= remaining - REM_BITS'(1);
            if (remaining == REM_BITS'(1)) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // checks
  `B2DA_ASSERT_NEXT(a_load_starts, clk, rst, din.valid && din.ready,
    (state == CONVERT) && (bit_cnt == BIT_CNT_BITS'(VALUE_BITS - 1)))
  `B2DA_ASSERT_IMPLIES(a_top_bcd, clk, rst, state == EMIT, top_digit <= BCD_BITS'(9))
  `B2DA_ASSERT_IMPLIES(a_rem_live, clk, rst, state == EMIT, remaining != '0)
  `B2DA_ASSERT_IMPLIES(a_char_range, clk, rst, out_valid,
    (out_char >= ASCII_ZERO) && (out_char <= ASCII_ZERO + CHAR_BITS'(9)))

endmodule

FILE: hdl/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double-dabble chain: add-3 correction and shift.
// ----------------------------------------------------------------------------
module b2da_cell
  import b2da_pkg::*;
(
  input  logic                clk,
  input  cell_op_t            op,
  input  logic                carry_in,
  input  logic [BCD_BITS-1:0] digit_in,
  output logic                carry_out,
  output logic [BCD_BITS-1:0] digit
);

  logic [BCD_BITS-1:0] adj;

  // add 3 when the digit would reach ten after doubling
  always_comb begin
    adj = (digit >= BCD_BITS'(5)) ? digit + BCD_BITS'(3) : digit;
  end

  assign carry_out = adj[BCD_BITS-1];

  // digit register
  always_ff @(posedge clk) begin
    case (op)
      OP_CLEAR:  digit <= '0;
      OP_DABBLE: digit <= {adj[BCD_BITS-2:0], carry_in};
      OP_DIGIT:  digit <= digit_in;
      default:   digit <= digit;
    endcase
  end

endmodule

FILE: hdl/b2da_chain.sv
// ----------------------------------------------------------------------------
// b2da_chain
// Row of digit cells; least significant cell takes the binary bit stream,
// digit shifts move every digit one cell toward the top.
// ----------------------------------------------------------------------------
module b2da_chain
  import b2da_pkg::*;
(
  input  logic                clk,
  input  cell_op_t            op,
  input  logic                bit_in,
  output logic [BCD_BITS-1:0] top_digit
);

  logic [BCD_BITS-1:0] digit [NUM_DIGITS];
  logic                carry [NUM_DIGITS];

  // cell row, neighbor to neighbor
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      b2da_cell u_cell (
        .clk       (clk),
        .op        (op),
        .carry_in  (bit_in),
        .digit_in  ('0),
        .carry_out (carry[i]),
        .digit     (digit[i])
      );
    end else begin : g_up
      b2da_cell u_cell (
        .clk       (clk),
        .op        (op),
        .carry_in  (carry[i-1]),
        .digit_in  (digit[i-1]),
        .carry_out (carry[i]),
        .digit     (digit[i])
      );
    end
  end

  assign top_digit = digit[NUM_DIGITS-1];

endmodule

FILE: verif/binary_to_decimal_ascii_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core_checker
// Watches both channels of the converter. Every accepted binary word is
// turned into its expected decimal characters, and every accepted output
// character is compared with the oldest one still pending.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core_checker
  import b2da_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  b2da_in_if         in_ch,
  b2da_out_if        out_ch,
  output int         fail_count,
  output int         words_done,
  output int         chars_pending
);

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } decimal_char_t;

  // only the low VALUE_BITS bits of a word are converted
  localparam logic [63:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

  decimal_char_t expected_chars[$];

  // split one word into decimal digits, most significant first
  function automatic void predict_decimal_chars(input logic [IN_BITS-1:0] word);
    logic [63:0]   rest;
    logic [3:0]    digits[$];
    decimal_char_t ch;
    rest = 64'(word) & VALUE_MASK;
    do begin
      digits.push_front(4'(rest % 64'd10));
      rest = rest / 64'd10;
    end while (rest != 64'd0 && digits.size() < 20);
    foreach (digits[k]) begin
      ch.digit_char = ASCII_ZERO + CHAR_BITS'(digits[k]);
      ch.last_digit = (k == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  initial begin
    fail_count    = 0;
    words_done    = 0;
    chars_pending = 0;
  end

  // outputs are checked before the input word of the same edge is predicted
  always @(posedge clk) begin
    decimal_char_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected character: expected none, actual %0d last %0b",
                   $time, out_ch.digit_char, out_ch.last_digit);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.digit_char !== want.digit_char ||
              out_ch.last_digit !== want.last_digit) begin
            fail_count++;
            $display("%0t: character mismatch: expected %0d last %0b, actual %0d last %0b",
                     $time, want.digit_char, want.last_digit,
                     out_ch.digit_char, out_ch.last_digit);
          end
          if (want.last_digit)
            words_done++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_decimal_chars(in_ch.value);
      chars_pending = expected_chars.size();
    end
  end

endmodule

FILE: verif/binary_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core_test
// Drives binary words into the converter: edge values first, then random
// words of mixed magnitude. Both sides idle in random bursts; the output
// side holds off once for a long stretch and the input side twice waits for
// the core to drain. A checker module predicts and compares the characters.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core_test;
  import b2da_pkg::*;

  localparam int NUM_RANDOM   = 436;
  localparam int CALM_WORDS   = 60;
  localparam int LONG_HOLD    = 700;
  localparam int SETTLE_TICKS = 60;

  localparam logic [31:0] EDGE_VALUES [24] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
    32'd999, 32'd1000, 32'd65535, 32'd65536, 32'd99999999, 32'd100000000,
    32'd999999999, 32'd1000000000, 32'd1000000001, 32'd2147483647,
    32'd2147483648, 32'd4294967294, 32'd4294967295, 32'h55555555,
    32'hAAAAAAAA, 32'd4000000000
  };

  logic clk = 1'b0;
  logic rst;

  int fail_count;
  int words_done;
  int chars_pending;
  int words_sent = 0;
  int hold_off_cycles = 0;
  bit calm_phase = 1'b0;

  b2da_in_if  in_ch ();
  b2da_out_if out_ch ();

  binary_to_decimal_ascii_core DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  binary_to_decimal_ascii_core_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_done    (words_done),
    .chars_pending (chars_pending)
  );

  always #6 clk = ~clk;

  // present one word and hold it until the core takes it
  task automatic send_word(input logic [IN_BITS-1:0] word);
    in_ch.valid <= 1'b1;
    in_ch.value <= word;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // stop offering words until every character has come out
  task automatic drain_core();
    in_ch.valid <= 1'b0;
    wait (words_done == words_sent && chars_pending == 0);
    @(posedge clk);
  endtask

  // random word: full range, short lengths, tiny values, near powers of ten, near the maximum
  function automatic logic [IN_BITS-1:0] random_word();
    logic [31:0] pow10;
    int          k;
    pow10 = 32'd1;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 99);
      3: begin
        k = $urandom_range(0, 9);
        repeat (k) pow10 = pow10 * 32'd10;
        return pow10 + 32'($urandom_range(0, 6)) - 32'd3;
      end
      default: return 32'hFFFFFFFF - 32'($urandom_range(0, 1000));
    endcase
  endfunction

  // output side: ready bursts, random stalls, one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // input side: reset, edge values, random words, verdict
  initial begin
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (EDGE_VALUES[i])
      send_word(EDGE_VALUES[i]);
    drain_core();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - CALM_WORDS)
        calm_phase = 1'b1;
      // keep offering words while the output side is held off
      if (n == 120)
        hold_off_cycles = LONG_HOLD;
      if (n == 260)
        drain_core();
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      send_word(random_word());
    end
    in_ch.valid <= 1'b0;

    wait (words_done == words_sent && chars_pending == 0);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_if.sv
hdl/b2da_cell.sv
hdl/b2da_chain.sv
hdl/binary_to_decimal_ascii_core.sv
verif/binary_to_decimal_ascii_core_checker.sv
verif/binary_to_decimal_ascii_core_test.sv
